>>> rtl/abr_pkg.sv
// Shared operation codes, condition codes, constants and stage types for the execute stage.
`timescale 1ns / 1ps

package abr_pkg;

    localparam int unsigned XLEN = 64;

    // Operation codes
    localparam logic [4:0] OP_ADD     = 5'd0;
    localparam logic [4:0] OP_ADDS    = 5'd1;
    localparam logic [4:0] OP_AND     = 5'd2;
    localparam logic [4:0] OP_ANDS    = 5'd3;
    localparam logic [4:0] OP_EOR     = 5'd4;
    localparam logic [4:0] OP_ORR     = 5'd5;
    localparam logic [4:0] OP_SUB     = 5'd6;
    localparam logic [4:0] OP_SUBS    = 5'd7;
    localparam logic [4:0] OP_MUL     = 5'd8;
    localparam logic [4:0] OP_ADDI    = 5'd9;
    localparam logic [4:0] OP_ADDIS   = 5'd10;
    localparam logic [4:0] OP_SHIFT   = 5'd11;
    localparam logic [4:0] OP_SUBI    = 5'd12;
    localparam logic [4:0] OP_SUBIS   = 5'd13;
    localparam logic [4:0] OP_MEMADDR = 5'd14;
    localparam logic [4:0] OP_BR      = 5'd15;
    localparam logic [4:0] OP_B       = 5'd16;
    localparam logic [4:0] OP_CBZ     = 5'd17;
    localparam logic [4:0] OP_CBNZ    = 5'd18;
    localparam logic [4:0] OP_BCOND   = 5'd19;
    localparam logic [4:0] OP_HLT     = 5'd20;
    localparam logic [4:0] OP_NOP     = 5'd21;

    // B.cond condition codes
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;

    // imms value that selects a logical right shift
    localparam logic [5:0] IMMS_LSR = 6'h3F;
    // Zero register number
    localparam logic [4:0] ZERO_REG = 5'd31;
    // Instruction size in bytes
    localparam logic [XLEN-1:0] INSTR_BYTES = 64'd4;

    // One accepted instruction
    typedef struct packed {
        logic [4:0]      operation;
        logic [XLEN-1:0] operand_a;
        logic [XLEN-1:0] operand_b;
        logic [11:0]     immediate;
        logic [25:0]     displacement;
        logic [XLEN-1:0] instr_address;
        logic [4:0]      dest_register;
        logic [3:0]      condition;
        logic            predicted_taken;
        logic            target_buffer_missed;
        logic [XLEN-1:0] predicted_target;
    } item_t;

    // ALU outputs; multiply leaves partial products for the next stage
    typedef struct packed {
        logic [XLEN-1:0] result;
        logic            is_mul;
        logic [XLEN-1:0] prod_ll;
        logic [31:0]     prod_lh;
        logic [31:0]     prod_hl;
        logic            flags_we;
        logic            flag_n;
        logic            flag_z;
        logic            halt;
    } alu_out_t;

    // Branch resolution outputs
    typedef struct packed {
        logic            taken;
        logic            redirect;
        logic [XLEN-1:0] redirect_address;
        logic            train_valid;
        logic            train_taken;
        logic            train_conditional;
        logic [XLEN-1:0] train_target;
    } br_out_t;

    // Execute stage register contents
    typedef struct packed {
        alu_out_t alu;
        logic     negative_flag;
        logic     zero_flag;
        br_out_t  br;
    } exec_t;

endpackage

>>> rtl/abr_alu.sv
// Arithmetic, logic, shift and address computation, flag generation, multiply partial products.
`timescale 1ns / 1ps

module abr_alu
(
    input  abr_pkg::item_t    item,
    output abr_pkg::alu_out_t alu
);

    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] imm_ext;
    logic [63:0] disp_ext;
    logic [5:0]  immr;
    logic [5:0]  imms;
    logic [63:0] shift_res;
    logic [63:0] sum_ab;
    logic [63:0] diff_ab;
    logic [63:0] sum_ai;
    logic [63:0] diff_ai;

    assign a        = item.operand_a;
    assign b        = item.operand_b;
    assign imm_ext  = {52'b0, item.immediate};
    assign disp_ext = {{38{item.displacement[25]}}, item.displacement};
    assign immr     = item.immediate[11:6];
    assign imms     = item.immediate[5:0];

    assign sum_ab  = a + b;
    assign diff_ab = a - b;
    assign sum_ai  = a + imm_ext;
    assign diff_ai = a - imm_ext;

    // LSR by immr when imms is all ones, else LSL by 63 - imms
    assign shift_res = (imms == abr_pkg::IMMS_LSR) ? (a >> immr)
                                                   : (a << (imms ^ abr_pkg::IMMS_LSR));

    // Multiply: three 32x32 products, summed in the next stage
    assign alu.prod_ll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    assign alu.prod_lh = a[31:0] * b[63:32];
    assign alu.prod_hl = a[63:32] * b[31:0];
    assign alu.is_mul  = (item.operation == abr_pkg::OP_MUL);
    assign alu.halt    = (item.operation == abr_pkg::OP_HLT);

    // Result select and flag source
    logic [63:0] flag_src;
    logic [63:0] result_sel;
    logic        flags_we_sel;
    always_comb
    begin
        result_sel   = '0;
        flags_we_sel = 1'b0;
        flag_src     = '0;
        case (item.operation)
            abr_pkg::OP_ADD:     result_sel = sum_ab;
            abr_pkg::OP_ADDS:
            begin
                result_sel   = sum_ab;
                flag_src     = sum_ab;
                flags_we_sel = 1'b1;
            end
            abr_pkg::OP_AND:     result_sel = a & b;
            abr_pkg::OP_ANDS:
            begin
                result_sel   = a & b;
                flag_src     = a & b;
                flags_we_sel = 1'b1;
            end
            abr_pkg::OP_EOR:     result_sel = a ^ b;
            abr_pkg::OP_ORR:     result_sel = a | b;
            abr_pkg::OP_SUB:     result_sel = diff_ab;
            abr_pkg::OP_SUBS:
            begin
                // flags from the raw difference; XZR target discards the value
                result_sel   = (item.dest_register == abr_pkg::ZERO_REG) ? '0 : diff_ab;
                flag_src     = diff_ab;
                flags_we_sel = 1'b1;
            end
            abr_pkg::OP_ADDI:    result_sel = sum_ai;
            abr_pkg::OP_ADDIS:
            begin
                result_sel   = sum_ai;
                flag_src     = sum_ai;
                flags_we_sel = 1'b1;
            end
            abr_pkg::OP_SHIFT:   result_sel = shift_res;
            abr_pkg::OP_SUBI:    result_sel = diff_ai;
            abr_pkg::OP_SUBIS:
            begin
                result_sel   = (item.dest_register == abr_pkg::ZERO_REG) ? '0 : diff_ai;
                flag_src     = diff_ai;
                flags_we_sel = 1'b1;
            end
            abr_pkg::OP_MEMADDR: result_sel = a + disp_ext;
            default:             result_sel = '0;
        endcase
    end

    assign alu.result   = result_sel;
    assign alu.flags_we = flags_we_sel;
    assign alu.flag_n   = flag_src[63];
    assign alu.flag_z   = (flag_src == '0);

endmodule

>>> rtl/abr_branch.sv
// Branch outcome, target, misprediction check and predictor training fields.
`timescale 1ns / 1ps

module abr_branch
(
    input  abr_pkg::item_t   item,
    input  logic             flag_n,
    input  logic             flag_z,
    input  logic             halt_seen,
    output abr_pkg::br_out_t br
);

    logic [63:0] ofs;
    logic [63:0] rel_target;
    logic [63:0] fall_through;
    logic [63:0] target;
    logic [63:0] next_pc;
    logic        branch_op;
    logic        conditional;
    logic        taken;
    logic        cond_ok;
    logic        redirect;

    // Word offset to byte offset, sign extended
    assign ofs          = {{36{item.displacement[25]}}, item.displacement, 2'b00};
    assign rel_target   = item.instr_address + ofs;
    assign fall_through = item.instr_address + abr_pkg::INSTR_BYTES;

    // Condition evaluation against stored flags
    always_comb
    begin
        case (item.condition)
            abr_pkg::COND_EQ: cond_ok = flag_z;
            abr_pkg::COND_NE: cond_ok = !flag_z;
            abr_pkg::COND_GE: cond_ok = !flag_n;
            abr_pkg::COND_LT: cond_ok = flag_n;
            abr_pkg::COND_GT: cond_ok = !flag_z && !flag_n;
            abr_pkg::COND_LE: cond_ok = flag_z || flag_n;
            default:          cond_ok = 1'b0;
        endcase
    end

    // Decode of branch kind and outcome
    always_comb
    begin
        branch_op   = 1'b1;
        conditional = 1'b0;
        taken       = 1'b0;
        target      = rel_target;
        case (item.operation)
            abr_pkg::OP_BR:
            begin
                taken  = 1'b1;
                target = item.operand_a;
            end
            abr_pkg::OP_B:     taken = 1'b1;
            abr_pkg::OP_CBZ:
            begin
                conditional = 1'b1;
                taken       = (item.operand_a == '0);
            end
            abr_pkg::OP_CBNZ:
            begin
                conditional = 1'b1;
                taken       = (item.operand_a != '0);
            end
            abr_pkg::OP_BCOND:
            begin
                conditional = 1'b1;
                taken       = cond_ok;
            end
            default:           branch_op = 1'b0;
        endcase
    end

    assign next_pc  = taken ? target : fall_through;
    assign redirect = (item.target_buffer_missed && !(conditional && !taken))
                   || (item.predicted_taken && (item.predicted_target != target))
                   || (item.predicted_taken != taken);

    // Everything zero unless a live branch resolves
    logic live;
    assign live = branch_op && !halt_seen;

    assign br.taken             = live && taken;
    assign br.redirect          = live && redirect;
    assign br.redirect_address  = (live && redirect) ? next_pc : '0;
    assign br.train_valid       = live;
    assign br.train_taken       = live && taken;
    assign br.train_conditional = live && conditional;
    assign br.train_target      = live ? next_pc : '0;

endmodule

>>> rtl/alu_branch_resolve_unit.sv
// Top level of the execute stage: input, execute and result registers with flag and halt state.
`timescale 1ns / 1ps

// Execute stage of a 64-bit scalar pipeline. One instruction can be transferred
// in every cycle while in_stall is low; its result passes through the input
// register, execute register and result register and can itself be transferred
// when out_stall is low. The 64-bit multiply is built from three 32x32 products
// in the execute cycle and summed on the way into the result register, which
// is why the execute register is there. The N and Z flags and the halt mark
// are updated as an instruction leaves the input register, so a B.cond right
// behind a flag-setting instruction sees the new flags. Stall propagates back
// through the three registers; each register refills in the cycle it is
// drained, so a stalled result does not block transfers into the empty registers
// behind it.
module alu_branch_resolve_unit
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         operation,
    input  logic signed [63:0] operand_a,
    input  logic signed [63:0] operand_b,
    input  logic [11:0]        immediate,
    input  logic signed [25:0] displacement,
    input  logic [63:0]        instr_address,
    input  logic [4:0]         dest_register,
    input  logic [3:0]         condition,
    input  logic               predicted_taken,
    input  logic               target_buffer_missed,
    input  logic [63:0]        predicted_target,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] alu_result,
    output logic               negative_flag,
    output logic               zero_flag,
    output logic               branch_taken,
    output logic               redirect,
    output logic [63:0]        redirect_address,
    output logic               train_valid,
    output logic               train_taken,
    output logic               train_conditional,
    output logic [63:0]        train_target
);

    // Stage occupancy and advance
    logic in_vld_reg;
    logic ex_vld_reg;
    logic out_vld_reg;
    logic out_ready;
    logic ex_ready;
    logic in_ready;
    logic in_xfer;
    logic ex_load;
    logic out_load;

    assign out_ready = !out_vld_reg || !out_stall;
    assign ex_ready  = !ex_vld_reg || out_ready;
    assign in_ready  = !in_vld_reg || ex_ready;
    assign in_stall  = !in_ready;
    assign in_xfer   = in_valid && in_ready;
    assign ex_load   = in_vld_reg && ex_ready;
    assign out_load  = ex_vld_reg && out_ready;

    // Input register
    abr_pkg::item_t item_reg;
    abr_pkg::item_t item_next;

    assign item_next.operation            = operation;
    assign item_next.operand_a            = operand_a;
    assign item_next.operand_b            = operand_b;
    assign item_next.immediate            = immediate;
    assign item_next.displacement         = displacement;
    assign item_next.instr_address        = instr_address;
    assign item_next.dest_register        = dest_register;
    assign item_next.condition            = condition;
    assign item_next.predicted_taken      = predicted_taken;
    assign item_next.target_buffer_missed = target_buffer_missed;
    assign item_next.predicted_target     = predicted_target;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= item_next;
        end
    end

    // Execute logic
    abr_pkg::alu_out_t alu;
    abr_pkg::br_out_t  br;
    logic              flag_n_reg;
    logic              flag_z_reg;
    logic              halt_reg;

    abr_alu u_alu
    (
        .item (item_reg),
        .alu  (alu)
    );

    abr_branch u_branch
    (
        .item      (item_reg),
        .flag_n    (flag_n_reg),
        .flag_z    (flag_z_reg),
        .halt_seen (halt_reg),
        .br        (br)
    );

    // Flag and halt state
    logic flag_n_next;
    logic flag_z_next;
    logic halt_next;

    assign flag_n_next = alu.flags_we ? alu.flag_n : flag_n_reg;
    assign flag_z_next = alu.flags_we ? alu.flag_z : flag_z_reg;
    assign halt_next   = halt_reg || alu.halt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_n_reg <= 1'b0;
            flag_z_reg <= 1'b0;
            halt_reg   <= 1'b0;
        end
        else if (ex_load)
        begin
            flag_n_reg <= flag_n_next;
            flag_z_reg <= flag_z_next;
            halt_reg   <= halt_next;
        end
    end

    // Execute register
    abr_pkg::exec_t ex_reg;
    abr_pkg::exec_t ex_next;

    assign ex_next.alu           = alu;
    assign ex_next.negative_flag = flag_n_next;
    assign ex_next.zero_flag     = flag_z_next;
    assign ex_next.br            = br;

    always_ff @(posedge clk)
    begin
        if (ex_load)
        begin
            ex_reg <= ex_next;
        end
    end

    // Result register; multiply partial products summed here
    logic [31:0]    cross_sum;
    logic [63:0]    res_next;
    abr_pkg::exec_t res_reg;
    logic [63:0]    res_val_reg;

    assign cross_sum = ex_reg.alu.prod_lh + ex_reg.alu.prod_hl;
    assign res_next  = ex_reg.alu.is_mul ? (ex_reg.alu.prod_ll + {cross_sum, 32'b0})
                                         : ex_reg.alu.result;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg     <= ex_reg;
            res_val_reg <= res_next;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            ex_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (ex_ready)
            begin
                ex_vld_reg <= in_vld_reg;
            end
            if (out_ready)
            begin
                out_vld_reg <= ex_vld_reg;
            end
        end
    end

    // Outputs
    assign out_valid         = out_vld_reg;
    assign alu_result        = res_val_reg;
    assign negative_flag     = res_reg.negative_flag;
    assign zero_flag         = res_reg.zero_flag;
    assign branch_taken      = res_reg.br.taken;
    assign redirect          = res_reg.br.redirect;
    assign redirect_address  = res_reg.br.redirect_address;
    assign train_valid       = res_reg.br.train_valid;
    assign train_taken       = res_reg.br.train_taken;
    assign train_conditional = res_reg.br.train_conditional;
    assign train_target      = res_reg.br.train_target;

    // Checks
    a_redirect_trains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && redirect |-> train_valid)
        else $error("redirect without a resolved branch");

    a_no_branch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !train_valid |-> !branch_taken && (redirect_address == '0))
        else $error("branch fields set for a non-branch");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        ex_load && alu.halt |=> halt_reg)
        else $error("halt not recorded");

    a_halt_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> !br.train_valid)
        else $error("branch resolved after halt");

endmodule
